### rtl/kbit_pkg.sv
package kbit_pkg;

   localparam int SLOTS        = 32;
   localparam int ENTITY_LIMIT = 4096;

   localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int DATA_W    = 32;
   localparam int CFG_W     = 16;
   localparam int AGE_W     = CFG_W;   // a live slot's age is below the lifetime
   localparam int CNT_W     = $clog2(AGE_W);
   localparam int CSR_IDX_W = 2;
   localparam int ALPHA_LSB = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_LIFETIME = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ON_TIME  = 2'd2;

   localparam logic [CFG_W-1:0] LIFETIME_RESET = 16'd1000;
   localparam logic [CFG_W-1:0] PERIOD_RESET   = 16'd500;
   localparam logic [CFG_W-1:0] ON_TIME_RESET  = 16'd250;

   // request travelling down the slot chain
   typedef struct packed {
      logic              live;
      logic              cmd;          // 0 set, 1 query
      logic              ok;           // set key in range
      logic              done;         // search finished
      logic              hit;          // query found a live match
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] color;
      logic [DATA_W-1:0] now;
      logic [IDX_W-1:0]  oldest_idx;
      logic [DATA_W-1:0] oldest_start;
      logic [AGE_W-1:0]  hit_age;
      logic [DATA_W-1:0] hit_color;
   } kbit_tok_type;

   // replacement write broadcast at the end of a set scan
   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  idx;
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] color;
      logic [DATA_W-1:0] start;
   } kbit_wr_type;

   localparam logic CMD_SET   = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

endpackage

### rtl/keyed_blink_indicator_table_core.sv
// Channel   Direction  Handshake                    Payload
// request   in         start & !busy                req_cmd, req_entity, req_color, req_now
// response  out        rsp_valid, one-cycle strobe  rsp_accepted, rsp_show, rsp_shown_color
// csr       in         csr_valid & csr_ready        csr_index, csr_wdata
//
// One request at a time. It walks the slot chain, one slot a cycle: a set or a
// query without a live match answers once it leaves the chain; a query with a
// match then runs the 16-step blink remainder and answers when it is done.
// Synchronous reset clears all slots and loads the default lifetime and blink times.
// Responses cannot be held off; csr_ready is always high.
module keyed_blink_indicator_table_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_cmd,
   input  logic signed [kbit_pkg::DATA_W-1:0] req_entity,
   input  logic [kbit_pkg::DATA_W-1:0]   req_color,
   input  logic [kbit_pkg::DATA_W-1:0]   req_now,
   output logic                          rsp_valid,
   output logic                          rsp_accepted,
   output logic                          rsp_show,
   output logic [kbit_pkg::DATA_W-1:0]   rsp_shown_color,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [kbit_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [kbit_pkg::CFG_W-1:0]    csr_wdata
);
   import kbit_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DIV} state_type;

   state_type         state_ff;
   logic [CFG_W-1:0]  lifetime_ff, period_ff, on_time_ff;
   kbit_tok_type      head_ff, req_tok, tok_last;
   kbit_tok_type      tok_chain [SLOTS+1];
   kbit_wr_type       wr_bus;
   logic [DATA_W-1:0] hit_color_ff;
   logic              rsp_valid_ff, rsp_accepted_ff, rsp_show_ff;
   logic [DATA_W-1:0] rsp_color_ff;

   logic              take_req, in_range, scan_end, div_start, div_done, phase_on;
   logic [AGE_W-1:0]  divisor, rem;

   assign take_req = start && !busy;
   assign busy     = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;

   // set keys must lie in 1 .. ENTITY_LIMIT-1
   assign in_range = !req_entity[DATA_W-1] && req_entity != '0
                     && req_entity < DATA_W'(ENTITY_LIMIT);

   always_comb begin
      req_tok              = '0;
      req_tok.live         = 1'b1;
      req_tok.cmd          = req_cmd;
      req_tok.ok           = in_range;
      // a rejected set or a query for entity zero touches no slot
      req_tok.done         = (req_cmd == CMD_QUERY) ? (req_entity == '0) : !in_range;
      req_tok.key          = req_entity;
      req_tok.color        = req_color;
      req_tok.now          = req_now;
      req_tok.oldest_start = '1;
   end

   // slot chain: each cell holds one slot and registers the request onward
   assign tok_chain[0] = head_ff;
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      kbit_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (IDX_W'(i)),
         .lifetime (lifetime_ff),
         .tok_i    (tok_chain[i]),
         .wr_i     (wr_bus),
         .tok_o    (tok_chain[i+1])
      );
   end
   assign tok_last = tok_chain[SLOTS];
   assign scan_end = state_ff == ST_SCAN && tok_last.live;

   // no free or matching slot: overwrite the oldest one
   always_comb begin
      wr_bus.en    = scan_end && tok_last.cmd == CMD_SET && tok_last.ok && !tok_last.done;
      wr_bus.idx   = tok_last.oldest_idx;
      wr_bus.key   = tok_last.key;
      wr_bus.color = tok_last.color;
      wr_bus.start = tok_last.now;
   end

   // blink phase: age mod period, a zero period counts as one
   assign div_start = scan_end && tok_last.cmd == CMD_QUERY && tok_last.hit;
   assign divisor   = (period_ff == '0) ? AGE_W'(1) : period_ff;
   assign phase_on  = rem < on_time_ff;

   kbit_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (tok_last.hit_age),
      .divisor  (divisor),
      .done     (div_done),
      .rem      (rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         lifetime_ff <= LIFETIME_RESET;
         period_ff   <= PERIOD_RESET;
         on_time_ff  <= ON_TIME_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LIFETIME: lifetime_ff <= csr_wdata;
            CSR_PERIOD:   period_ff   <= csr_wdata;
            CSR_ON_TIME:  on_time_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff.live <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take_req) begin
            head_ff <= req_tok;
         end else begin
            head_ff.live <= 1'b0;
         end
         // strobe on a plain scan end or when the remainder is ready
         rsp_valid_ff <= (state_ff == ST_SCAN && tok_last.live && !div_start)
                         || (state_ff == ST_DIV && div_done);
         case (state_ff)
            ST_IDLE: begin
               if (take_req) begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (tok_last.live) begin
                  hit_color_ff <= tok_last.hit_color;
                  if (div_start) begin
                     state_ff <= ST_DIV;
                  end else begin
                     rsp_accepted_ff <= tok_last.cmd == CMD_SET && tok_last.ok;
                     rsp_show_ff     <= 1'b0;
                     rsp_color_ff    <= '0;
                     state_ff        <= ST_IDLE;
                  end
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  rsp_accepted_ff <= 1'b1;
                  rsp_show_ff     <= phase_on;
                  rsp_color_ff    <= phase_on ? hit_color_ff : '0;
                  state_ff        <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = rsp_accepted_ff;
   assign rsp_show        = rsp_show_ff;
   assign rsp_shown_color = rsp_color_ff;

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for two cycles");

   a_show_needs_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_show |-> rsp_accepted)
      else $error("blink shown without a match");

   a_dark_colour: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_show |-> rsp_shown_color == '0)
      else $error("colour given while not shown");

   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      take_req |=> busy)
      else $error("request taken but block not busy");

   a_chain_end: assert property (@(posedge clock) disable iff (reset)
      tok_last.live |-> state_ff == ST_SCAN)
      else $error("request left slot chain outside scan");

   a_rem_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("remainder finished outside blink phase step");

endmodule

### rtl/kbit_cell.sv
module kbit_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [kbit_pkg::IDX_W-1:0]  cell_idx,
   input  logic [kbit_pkg::CFG_W-1:0]  lifetime,
   input  kbit_pkg::kbit_tok_type      tok_i,
   input  kbit_pkg::kbit_wr_type       wr_i,
   output kbit_pkg::kbit_tok_type      tok_o
);
   import kbit_pkg::*;

   logic              active_ff, active_in;
   logic [DATA_W-1:0] key_ff, color_ff, start_ff;
   kbit_tok_type      tok_ff, tok_in;

   logic              searching, key_eq, take_set, take_wr, expire, match;
   logic [DATA_W-1:0] age;
   logic [DATA_W-1:0] wr_key, wr_color, wr_start;

   assign searching = tok_i.live && !tok_i.done;
   assign key_eq    = key_ff == tok_i.key;
   assign age       = tok_i.now - start_ff;
   assign take_set  = searching && tok_i.cmd == CMD_SET && (!active_ff || key_eq);
   assign take_wr   = wr_i.en && wr_i.idx == cell_idx;
   assign expire    = searching && tok_i.cmd == CMD_QUERY && active_ff
                      && age >= {{(DATA_W-CFG_W){1'b0}}, lifetime};
   assign match     = searching && tok_i.cmd == CMD_QUERY && active_ff && !expire && key_eq;

   assign wr_key   = take_set ? tok_i.key   : wr_i.key;
   assign wr_color = take_set ? tok_i.color : wr_i.color;
   assign wr_start = take_set ? tok_i.now   : wr_i.start;

   always_comb begin
      active_in = active_ff;
      if (take_set || take_wr) begin
         active_in = wr_color[DATA_W-1:ALPHA_LSB] != '0;
      end else if (expire) begin
         active_in = 1'b0;
      end

      tok_in = tok_i;
      if (take_set) begin
         tok_in.done = 1'b1;
      end else if (searching && tok_i.cmd == CMD_SET && start_ff < tok_i.oldest_start) begin
         // active slot, other key
         tok_in.oldest_idx   = cell_idx;
         tok_in.oldest_start = start_ff;
      end
      if (match) begin
         tok_in.done      = 1'b1;
         tok_in.hit       = 1'b1;
         tok_in.hit_age   = age[AGE_W-1:0];
         tok_in.hit_color = color_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         tok_ff.live <= 1'b0;
      end else begin
         active_ff <= active_in;
         tok_ff    <= tok_in;
      end
      if (take_set || take_wr) begin
         key_ff   <= wr_key;
         color_ff <= wr_color;
         start_ff <= wr_start;
      end
   end

   assign tok_o = tok_ff;

endmodule

### rtl/kbit_rem.sv
module kbit_rem (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [kbit_pkg::AGE_W-1:0]  dividend,
   input  logic [kbit_pkg::AGE_W-1:0]  divisor,
   output logic                        done,
   output logic [kbit_pkg::AGE_W-1:0]  rem
);
   import kbit_pkg::*;

   logic             busy_ff, done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [AGE_W-1:0] rem_ff, rem_in, dvd_ff, dsr_ff;
   logic [AGE_W:0]   trial;

   // restoring step, one dividend bit a cycle
   assign trial  = {rem_ff, dvd_ff[AGE_W-1]};
   assign rem_in = (trial >= {1'b0, dsr_ff}) ? AGE_W'(trial - {1'b0, dsr_ff})
                                             : AGE_W'(trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && !start && cnt_ff == CNT_W'(AGE_W-1);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            dvd_ff  <= dividend;
            dsr_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            dvd_ff <= {dvd_ff[AGE_W-2:0], 1'b0};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(AGE_W-1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule
